### sv/pws_pkg.sv
// Package for the profile window scanner: field widths, codes and shared types.
// Used by pws_score_bank, pws_window and pssm_window_scan.
package pws_pkg;

    localparam int SYM_W          = 8;
    localparam int COL_W          = 6;
    localparam int SCORE_W        = 16;
    localparam int SUM_W          = 24;
    localparam int POS_W          = 32;
    localparam int PLEN_W         = 7;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 24;
    localparam int ALPHABET_DEF   = 32;
    localparam int MAX_LENGTH_DEF = 64;
    localparam logic [PLEN_W-1:0] PLEN_RESET = 7'd8;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_SCAN = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_PROFILE_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SCORE      = 1'b1;

    typedef struct packed {
        logic special;
        logic restart;
    } scan_ctl_t;

    typedef struct packed {
        logic                    hit;
        logic [POS_W-1:0]        start;
        logic signed [SUM_W-1:0] score;
    } scan_res_t;

    function automatic logic signed [SUM_W-1:0] sext_score(input logic signed [SCORE_W-1:0] v);
        return {{(SUM_W-SCORE_W){v[SCORE_W-1]}}, v};
    endfunction

endpackage

### sv/pssm_window_scan.sv
// Top level of the profile window scanner: request and result channels,
// configuration registers, score table columns and the result register.
// Depends on pws_pkg, pws_score_bank and pws_window.
//
// Usage: a load request (operation 0) writes score_value into the table at
// symbol and column; loads outside the table are dropped. A scan request
// (operation 1) feeds one symbol; restart starts a new sequence at position 0.
// Symbols at or above ALPHABET break every open window.
// A scan request reads its table row into the read registers at acceptance;
// the window sums and the result register update together as that row is
// used. One request is taken per cycle unless a held result stalls the
// pending scan; one read of the column memories per request sets that rate.
// A scan that completes a window of profile_length symbols whose total is at
// least min_score gives one result with the window's start and total.
// Reset clears positions, windows and configuration (profile_length 8,
// min_score 0); table contents are undefined until loaded.
// When out_ready is low with a result held, the pending scan waits and
// in_ready falls in the same cycle; nothing is dropped.
// Configuration writes are taken at any time and belong to idle periods.
module pssm_window_scan
    import pws_pkg::*;
#(
    parameter int ALPHABET   = ALPHABET_DEF,
    parameter int MAX_LENGTH = MAX_LENGTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         operation,
    input  logic [SYM_W-1:0]             symbol,
    input  logic [COL_W-1:0]             column,
    input  logic signed [SCORE_W-1:0]    score_value,
    input  logic                         restart,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [POS_W-1:0]             match_start,
    output logic signed [SUM_W-1:0]      match_score,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data
);

    localparam int ADDR_W = $clog2(ALPHABET);
    localparam int CNT_W  = $clog2(MAX_LENGTH + 1);

    logic                    in_accept;
    logic                    sym_ok;
    logic                    step;
    logic                    out_free;
    logic [ADDR_W-1:0]       sym_addr;
    logic signed [SCORE_W-1:0] row [MAX_LENGTH];
    logic [CNT_W-1:0]        width;
    scan_ctl_t               s1_ctl_reg;
    scan_ctl_t               s1_ctl_next;
    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [POS_W-1:0]        match_start_reg;
    logic signed [SUM_W-1:0] match_score_reg;
    logic [PLEN_W-1:0]       profile_length_reg;
    logic signed [SUM_W-1:0] min_score_reg;
    scan_res_t               result;

    assign sym_ok    = int'(symbol) < ALPHABET;
    assign sym_addr  = ADDR_W'(symbol);
    assign out_free  = !out_valid_reg || out_ready;
    assign step      = s1_valid_reg && out_free;
    assign in_ready  = !s1_valid_reg || out_free;
    assign in_accept = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    for (genvar g = 0; g < MAX_LENGTH; g++)
    begin : g_col
        pws_score_bank #(
            .ALPHABET (ALPHABET)
        ) u_bank (
            .clk     (clk),
            .wr_en   (in_accept && (operation == OP_LOAD) && sym_ok && (int'(column) == g)),
            .wr_addr (sym_addr),
            .wr_data (score_value),
            .rd_en   (in_accept && (operation == OP_SCAN)),
            .rd_addr (sym_addr),
            .rd_data (row[g])
        );
    end

    always_comb
    begin
        if (int'(profile_length_reg) < 2)
        begin
            width = CNT_W'(2);
        end
        else if (int'(profile_length_reg) > MAX_LENGTH)
        begin
            width = CNT_W'(MAX_LENGTH);
        end
        else
        begin
            width = CNT_W'(profile_length_reg);
        end
    end

    pws_window #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .ctl       (s1_ctl_reg),
        .row       (row),
        .width     (width),
        .min_score (min_score_reg),
        .result    (result)
    );

    always_comb
    begin
        s1_ctl_next   = s1_ctl_reg;
        s1_valid_next = s1_valid_reg && !step;
        if (in_accept && (operation == OP_SCAN))
        begin
            s1_valid_next       = 1'b1;
            s1_ctl_next.special = !sym_ok;
            s1_ctl_next.restart = restart;
        end
        if (step)
        begin
            out_valid_next = result.hit;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg       <= 1'b0;
            s1_ctl_reg         <= '0;
            out_valid_reg      <= 1'b0;
            profile_length_reg <= PLEN_RESET;
            min_score_reg      <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s1_ctl_reg    <= s1_ctl_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_PROFILE_LENGTH: profile_length_reg <= cfg_data[PLEN_W-1:0];
                    REG_MIN_SCORE:      min_score_reg      <= signed'(cfg_data[SUM_W-1:0]);
                    default:            min_score_reg      <= min_score_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && result.hit)
        begin
            match_start_reg <= result.start;
            match_score_reg <= result.score;
        end
    end

    assign out_valid   = out_valid_reg;
    assign match_start = match_start_reg;
    assign match_score = match_score_reg;

endmodule

### sv/pws_score_bank.sv
// One column of the score table: a small memory indexed by symbol with a
// registered read port. Depends on pws_pkg.
module pws_score_bank
    import pws_pkg::*;
#(
    parameter int ALPHABET = ALPHABET_DEF
)
(
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [$clog2(ALPHABET)-1:0]       wr_addr,
    input  logic signed [SCORE_W-1:0]         wr_data,
    input  logic                              rd_en,
    input  logic [$clog2(ALPHABET)-1:0]       rd_addr,
    output logic signed [SCORE_W-1:0]         rd_data
);

    logic signed [SCORE_W-1:0] mem [ALPHABET];
    logic signed [SCORE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/pws_window.sv
// Window state of the scanner: partial sums, clean run and position, with the
// match decision for the symbol in flight. Depends on pws_pkg.
module pws_window
    import pws_pkg::*;
#(
    parameter int MAX_LENGTH = MAX_LENGTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              step,
    input  scan_ctl_t                         ctl,
    input  logic signed [SCORE_W-1:0]         row [MAX_LENGTH],
    input  logic [$clog2(MAX_LENGTH+1)-1:0]   width,
    input  logic signed [SUM_W-1:0]           min_score,
    output scan_res_t                         result
);

    localparam int CNT_W = $clog2(MAX_LENGTH + 1);
    localparam int IDX_W = $clog2(MAX_LENGTH);

    logic signed [SUM_W-1:0] ps_reg  [MAX_LENGTH];
    logic signed [SUM_W-1:0] ps_next [MAX_LENGTH];
    logic signed [SUM_W-1:0] sum_new [MAX_LENGTH];
    logic [CNT_W-1:0]        clean_reg;
    logic [CNT_W-1:0]        clean_next;
    logic [CNT_W-1:0]        clean_base;
    logic [POS_W-1:0]        pos_reg;
    logic [POS_W-1:0]        pos_next;
    logic [POS_W-1:0]        pos_base;
    logic [IDX_W-1:0]        last_idx;
    logic signed [SUM_W-1:0] win_sum;

    always_comb
    begin
        sum_new[0] = sext_score(row[0]);
        for (int d = 1; d < MAX_LENGTH; d++)
        begin
            sum_new[d] = (ctl.restart ? '0 : ps_reg[d-1]) + sext_score(row[d]);
        end
        for (int d = 0; d < MAX_LENGTH; d++)
        begin
            ps_next[d] = ctl.special ? '0 : sum_new[d];
        end
    end

    always_comb
    begin
        clean_base = ctl.restart ? '0 : clean_reg;
        if (ctl.special)
        begin
            clean_next = '0;
        end
        else if (clean_base == CNT_W'(MAX_LENGTH))
        begin
            clean_next = clean_base;
        end
        else
        begin
            clean_next = clean_base + CNT_W'(1);
        end
        pos_base = ctl.restart ? '0 : pos_reg;
        pos_next = (pos_base == '1) ? pos_base : pos_base + POS_W'(1);
    end

    assign last_idx = IDX_W'(width - CNT_W'(1));
    assign win_sum  = sum_new[last_idx];

    assign result.hit   = !ctl.special && (clean_next >= width) && (win_sum >= min_score);
    assign result.start = pos_base - POS_W'(last_idx);
    assign result.score = win_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < MAX_LENGTH; d++)
            begin
                ps_reg[d] <= '0;
            end
            clean_reg <= '0;
            pos_reg   <= '0;
        end
        else if (step)
        begin
            for (int d = 0; d < MAX_LENGTH; d++)
            begin
                ps_reg[d] <= ps_next[d];
            end
            clean_reg <= clean_next;
            pos_reg   <= pos_next;
        end
    end

endmodule
